/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the record table.
// No dependencies; included by krt_dp, the only module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define KRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define KRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/krt_pkg.sv */
// Package for the keyed record table: sizes, codes, control word and microprogram.
// No dependencies; used by every module of the block except krt_ram.
`timescale 1ns / 1ps

package krt_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = 32;
    localparam int RW = 3 * KW;
    localparam int EW = 11;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_MISSING   = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int UPC_W = 4;

    // sequencing modes
    localparam logic [2:0] SQ_NEXT = 3'd0;
    localparam logic [2:0] SQ_GOTO = 3'd1;
    localparam logic [2:0] SQ_IF   = 3'd2;
    localparam logic [2:0] SQ_WAIT = 3'd3;
    localparam logic [2:0] SQ_DISP = 3'd4;

    // branch conditions
    localparam logic [2:0] C_START = 3'd0;
    localparam logic [2:0] C_OFREE = 3'd1;
    localparam logic [2:0] C_FULL  = 3'd2;
    localparam logic [2:0] C_END   = 3'd3;
    localparam logic [2:0] C_NEQ   = 3'd4;
    localparam logic [2:0] C_INS   = 3'd5;
    localparam logic [2:0] C_LAST  = 3'd6;

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_IDX  = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_UPD  = 2'd1;
    localparam logic [1:0] WR_MOVE = 2'd2;
    localparam logic [1:0] WR_APP  = 2'd3;

    localparam logic [1:0] CN_HOLD = 2'd0;
    localparam logic [1:0] CN_INC  = 2'd1;
    localparam logic [1:0] CN_DEC  = 2'd2;

    // microprogram addresses
    localparam logic [UPC_W-1:0] U_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] U_CHK  = 4'd1;
    localparam logic [UPC_W-1:0] U_RD   = 4'd2;
    localparam logic [UPC_W-1:0] U_CMP  = 4'd3;
    localparam logic [UPC_W-1:0] U_HIT  = 4'd4;
    localparam logic [UPC_W-1:0] U_DUP  = 4'd5;
    localparam logic [UPC_W-1:0] U_SRCH = 4'd6;
    localparam logic [UPC_W-1:0] U_UPD  = 4'd7;
    localparam logic [UPC_W-1:0] U_SHR  = 4'd8;
    localparam logic [UPC_W-1:0] U_SHW  = 4'd9;
    localparam logic [UPC_W-1:0] U_DEC  = 4'd10;
    localparam logic [UPC_W-1:0] U_INS  = 4'd11;
    localparam logic [UPC_W-1:0] U_FULL = 4'd12;
    localparam logic [UPC_W-1:0] U_MISS = 4'd13;
    localparam logic [UPC_W-1:0] U_MSET = 4'd14;
    localparam logic [UPC_W-1:0] U_FIN  = 4'd15;

    typedef struct packed {
        logic [2:0]       sq;
        logic [2:0]       cond;
        logic [UPC_W-1:0] tgt;
        logic             ld_in;
        logic [1:0]       rd;
        logic [1:0]       wr;
        logic             ix_inc;
        logic [1:0]       cnt;
        logic             set_st;
        logic [1:0]       st;
        logic             ld_found;
        logic             out_ld;
    } t_uctl;

    typedef struct packed {
        logic       start;
        logic       ofree;
        logic       full;
        logic       at_end;
        logic       neq;
        logic       ins;
        logic       last;
        logic [1:0] cmd;
    } t_flags;

    // ld_in, ix_inc and out_ld act only when the step's branch is taken
    function automatic t_uctl uc_rom(input logic [UPC_W-1:0] pc);
        t_uctl u;
        u = '0;
        case (pc)
            U_IDLE: begin
                u.sq = SQ_WAIT; u.cond = C_START; u.tgt = U_CHK; u.ld_in = 1'b1;
            end
            U_CHK: begin
                u.sq = SQ_IF; u.cond = C_FULL; u.tgt = U_FULL;
            end
            U_RD: begin
                u.sq = SQ_IF; u.cond = C_END; u.tgt = U_MISS; u.rd = RD_IDX;
            end
            U_CMP: begin
                u.sq = SQ_IF; u.cond = C_NEQ; u.tgt = U_RD; u.ix_inc = 1'b1;
            end
            U_HIT: begin
                u.sq = SQ_DISP; u.tgt = U_DUP;
            end
            U_DUP: begin
                u.sq = SQ_GOTO; u.tgt = U_FIN; u.set_st = 1'b1; u.st = ST_DUPLICATE;
            end
            U_SRCH: begin
                u.sq = SQ_GOTO; u.tgt = U_FIN; u.ld_found = 1'b1;
            end
            U_UPD: begin
                u.sq = SQ_GOTO; u.tgt = U_FIN; u.wr = WR_UPD;
            end
            U_SHR: begin
                u.sq = SQ_IF; u.cond = C_LAST; u.tgt = U_DEC; u.rd = RD_NEXT;
            end
            U_SHW: begin
                u.sq = SQ_GOTO; u.tgt = U_SHR; u.wr = WR_MOVE; u.ix_inc = 1'b1;
            end
            U_DEC: begin
                u.sq = SQ_GOTO; u.tgt = U_FIN; u.cnt = CN_DEC;
            end
            U_INS: begin
                u.sq = SQ_GOTO; u.tgt = U_FIN; u.wr = WR_APP; u.cnt = CN_INC;
            end
            U_FULL: begin
                u.sq = SQ_GOTO; u.tgt = U_FIN; u.set_st = 1'b1; u.st = ST_FULL;
            end
            U_MISS: begin
                u.sq = SQ_IF; u.cond = C_INS; u.tgt = U_INS;
            end
            U_MSET: begin
                u.sq = SQ_NEXT; u.set_st = 1'b1; u.st = ST_MISSING;
            end
            U_FIN: begin
                u.sq = SQ_WAIT; u.cond = C_OFREE; u.tgt = U_IDLE; u.out_ld = 1'b1;
            end
            default: begin
                u = '0;
            end
        endcase
        return u;
    endfunction

endpackage

/* hw/rtl/krt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/krt_seq.sv */
// Microcode sequencer: step counter, control ROM lookup and branch logic.
// Depends on krt_pkg.
`timescale 1ns / 1ps

module krt_seq import krt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uctl  o_uctl,
    output logic   o_go
);

    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    t_uctl            u;
    logic             take;

    assign u = uc_rom(r_pc);

    always_comb begin
        case (u.cond)
            C_START: take = i_flags.start;
            C_OFREE: take = i_flags.ofree;
            C_FULL:  take = i_flags.full;
            C_END:   take = i_flags.at_end;
            C_NEQ:   take = i_flags.neq;
            C_INS:   take = i_flags.ins;
            C_LAST:  take = i_flags.last;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        case (u.sq)
            SQ_NEXT: begin
                n_pc = r_pc + 1'b1;
                o_go = 1'b1;
            end
            SQ_GOTO: begin
                n_pc = u.tgt;
                o_go = 1'b1;
            end
            SQ_IF: begin
                n_pc = take ? u.tgt : r_pc + 1'b1;
                o_go = take;
            end
            SQ_WAIT: begin
                n_pc = take ? u.tgt : r_pc;
                o_go = take;
            end
            SQ_DISP: begin
                n_pc = u.tgt + {{(UPC_W-2){1'b0}}, i_flags.cmd};
                o_go = 1'b1;
            end
            default: begin
                n_pc = U_IDLE;
                o_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uctl = u;

endmodule

/* hw/rtl/krt_dp.sv */
// Datapath: record RAM, scan index, entry count, command and result registers.
// Depends on krt_pkg, krt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module krt_dp import krt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_uctl         i_uctl,
    input  logic          i_go,
    output t_flags        o_flags,
    input  logic          i_in_valid,
    input  logic [1:0]    i_command,
    input  logic [KW-1:0] i_record_key,
    input  logic [KW-1:0] i_new_stock,
    input  logic [KW-1:0] i_new_price,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_status,
    output logic [KW-1:0] o_found_stock,
    output logic [KW-1:0] o_found_price,
    output logic [EW-1:0] o_entry_count
);

    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [KW-1:0] r_stock;
    logic [KW-1:0] r_price;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [1:0]    r_status;
    logic [KW-1:0] r_fstock;
    logic [KW-1:0] r_fprice;
    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [KW-1:0] r_ostock;
    logic [KW-1:0] r_oprice;
    logic [EW-1:0] r_ocount;

    logic [CW-1:0] idx1;
    logic [RW-1:0] rdata;
    logic [KW-1:0] rd_key;
    logic [KW-1:0] rd_stock;
    logic [KW-1:0] rd_price;
    logic          we;
    logic [AW-1:0] waddr;
    logic [RW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic          take_in;
    logic          take_out;
    logic          ofree;

    assign idx1     = r_idx + CW'(1);
    assign rd_key   = rdata[RW-1 -: KW];
    assign rd_stock = rdata[2*KW-1 -: KW];
    assign rd_price = rdata[KW-1:0];
    assign take_in  = i_uctl.ld_in & i_go;
    assign take_out = i_uctl.out_ld & i_go;
    assign ofree    = !r_ovalid || !i_out_stall;

    assign re    = (i_uctl.rd != RD_NONE);
    assign raddr = (i_uctl.rd == RD_NEXT) ? idx1[AW-1:0] : r_idx[AW-1:0];
    assign we    = (i_uctl.wr != WR_NONE);

    always_comb begin
        case (i_uctl.wr)
            WR_UPD: begin
                waddr = r_idx[AW-1:0];
                wdata = {rd_key, r_stock, rd_price};
            end
            WR_MOVE: begin
                waddr = r_idx[AW-1:0];
                wdata = rdata;
            end
            WR_APP: begin
                waddr = r_count[AW-1:0];
                wdata = {r_key, r_stock, r_price};
            end
            default: begin
                waddr = r_idx[AW-1:0];
                wdata = rdata;
            end
        endcase
    end

    krt_ram #(
        .WIDTH(RW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        o_flags.start  = i_in_valid;
        o_flags.ofree  = ofree;
        o_flags.full   = (r_cmd == CMD_INSERT) && (r_count == CW'(CAPACITY));
        o_flags.at_end = (r_idx == r_count);
        o_flags.neq    = (rd_key != r_key);
        o_flags.ins    = (r_cmd == CMD_INSERT);
        o_flags.last   = (idx1 == r_count);
        o_flags.cmd    = r_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (take_in) begin
                r_idx <= '0;
            end else if (i_uctl.ix_inc && i_go) begin
                r_idx <= idx1;
            end
            case (i_uctl.cnt)
                CN_INC:  r_count <= r_count + CW'(1);
                CN_DEC:  r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
            if (take_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_cmd    <= i_command;
            r_key    <= i_record_key;
            r_stock  <= i_new_stock;
            r_price  <= i_new_price;
            r_status <= ST_DONE;
            r_fstock <= '0;
            r_fprice <= '0;
        end else begin
            if (i_uctl.set_st) begin
                r_status <= i_uctl.st;
            end
            if (i_uctl.ld_found) begin
                r_fstock <= rd_stock;
                r_fprice <= rd_price;
            end
        end
        if (take_out) begin
            r_ostatus <= r_status;
            r_ostock  <= r_fstock;
            r_oprice  <= r_fprice;
            r_ocount  <= EW'(r_count);
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_found_stock = r_ostock;
    assign o_found_price = r_oprice;
    assign o_entry_count = r_ocount;

    `KRT_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `KRT_ASSERT_IMP(a_idx_in_use, i_clk, i_rst_n, 1'b1, r_idx <= r_count)
    `KRT_ASSERT_IMP(a_out_no_overrun, i_clk, i_rst_n, take_out, !(r_ovalid && i_out_stall))
    `KRT_ASSERT_IMP(a_app_below_cap, i_clk, i_rst_n, i_uctl.wr == WR_APP,
                    r_count < CW'(CAPACITY))

endmodule

/* hw/rtl/keyed_record_table_linear_core.sv */
// Top level of the keyed record table: microcode sequencer plus datapath.
// Depends on krt_pkg, krt_seq and krt_dp.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | command, key, stock, price
//   out     | output    | o_out_valid / i_out_stall | status, stock, price, count
//
// One command at a time; a command scans the entries in turn (RAM read, then key
// compare), and a delete then moves each entry behind the hit down one place.
// An insert into a full table skips the scan.
// The next word is taken while a result still sits in the output register; a stalled
// result holds the sequencer in its last step until the output register frees.
// Reset (synchronous, active low) clears the entry count and holds o_in_stall high;
// no clearing pass.
`timescale 1ns / 1ps

module keyed_record_table_linear_core import krt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_command,
    input  logic [KW-1:0] i_record_key,
    input  logic [KW-1:0] i_new_stock,
    input  logic [KW-1:0] i_new_price,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_status,
    output logic [KW-1:0] o_found_stock,
    output logic [KW-1:0] o_found_price,
    output logic [EW-1:0] o_entry_count
);

    t_uctl  uctl;
    t_flags flags;
    logic   go;

    krt_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_flags(flags),
        .o_uctl (uctl),
        .o_go   (go)
    );

    krt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uctl       (uctl),
        .i_go         (go),
        .o_flags      (flags),
        .i_in_valid   (i_in_valid),
        .i_command    (i_command),
        .i_record_key (i_record_key),
        .i_new_stock  (i_new_stock),
        .i_new_price  (i_new_price),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_found_stock(o_found_stock),
        .o_found_price(o_found_price),
        .o_entry_count(o_entry_count)
    );

    assign o_in_stall = !uctl.ld_in || !i_rst_n;

endmodule
